### hdl/wfe_pkg.sv
// ----------------------------------------------------------------------------
// wfe_pkg
// Shared types, constants and the brightness table for the frame encoder.
// ----------------------------------------------------------------------------
package wfe_pkg;

  localparam int NUM_LEDS     = 16;
  localparam int RESET_SLOTS  = 40;
  localparam int BITS_PER_LED = 24;
  localparam int MAX_SLOTS    = BITS_PER_LED + RESET_SLOTS;
  localparam int SLOT_W       = $clog2(MAX_SLOTS);
  localparam int LED_W        = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;

  localparam int MAX_ANGLE    = 45;
  localparam int ANGLE_W      = 6;
  localparam int COEF_W       = 17;

  // floor(x/100) == (x*5243) >> 19 for every x below 43000
  localparam int DIV100_MULT  = 5243;
  localparam int DIV100_SHIFT = 19;
  localparam int ONE_MULT     = 66 * DIV100_MULT;
  localparam int ZERO_MULT    = 33 * DIV100_MULT;

  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [BITS_PER_LED-1:0] word;
    logic                    frame_last;
  } entry_t;

  // round(tan(angle deg) * 65536), angle 45 is exactly 1.0
  function automatic logic [COEF_W-1:0] tan_coef(input logic [ANGLE_W-1:0] angle);
    logic [COEF_W-1:0] c;
    unique case (angle)
      6'd0:  c = 17'd0;     6'd1:  c = 17'd1144;  6'd2:  c = 17'd2289;
      6'd3:  c = 17'd3435;  6'd4:  c = 17'd4583;  6'd5:  c = 17'd5734;
      6'd6:  c = 17'd6888;  6'd7:  c = 17'd8047;  6'd8:  c = 17'd9210;
      6'd9:  c = 17'd10380; 6'd10: c = 17'd11556; 6'd11: c = 17'd12739;
      6'd12: c = 17'd13930; 6'd13: c = 17'd15130; 6'd14: c = 17'd16340;
      6'd15: c = 17'd17560; 6'd16: c = 17'd18792; 6'd17: c = 17'd20036;
      6'd18: c = 17'd21294; 6'd19: c = 17'd22566; 6'd20: c = 17'd23853;
      6'd21: c = 17'd25157; 6'd22: c = 17'd26478; 6'd23: c = 17'd27818;
      6'd24: c = 17'd29179; 6'd25: c = 17'd30560; 6'd26: c = 17'd31964;
      6'd27: c = 17'd33392; 6'd28: c = 17'd34846; 6'd29: c = 17'd36327;
      6'd30: c = 17'd37837; 6'd31: c = 17'd39378; 6'd32: c = 17'd40951;
      6'd33: c = 17'd42560; 6'd34: c = 17'd44205; 6'd35: c = 17'd45889;
      6'd36: c = 17'd47615; 6'd37: c = 17'd49385; 6'd38: c = 17'd51202;
      6'd39: c = 17'd53070; 6'd40: c = 17'd54991; 6'd41: c = 17'd56970;
      6'd42: c = 17'd59009; 6'd43: c = 17'd61113; 6'd44: c = 17'd63287;
      default: c = 17'd65536;
    endcase
    return c;
  endfunction

endpackage

### hdl/ws2812_frame_encoder_dimmed_core.sv
// ----------------------------------------------------------------------------
// ws2812_frame_encoder_dimmed_core
// Per-LED dimmed WS2812 PWM duty encoder with frame reset slots.
// ----------------------------------------------------------------------------
// path: front stage register, queue, back end word register, duty output register
// throughput: 24 duty slots per LED item, 64 for the last LED of a frame; the
//   back end emits one duty slot per cycle while pop keeps taking them, and that sets the rate
// reset: rst clears the queue, the frame position and all pending results,
//   and loads timer_top with 89
module ws2812_frame_encoder_dimmed_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  input  logic [7:0] brightness,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] duty,
  output logic       last_of_item,
  output logic       frame_end,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  logic            fq_push;
  logic            fq_full;
  wfe_pkg::entry_t fq_entry;
  logic            qb_pop;
  logic            qb_empty;
  wfe_pkg::entry_t qb_entry;

  wfe_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .brightness (brightness),
    .q_push     (fq_push),
    .q_entry    (fq_entry),
    .q_full     (fq_full)
  );

  wfe_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (fq_push),
    .push_entry (fq_entry),
    .full       (fq_full),
    .pop        (qb_pop),
    .pop_entry  (qb_entry),
    .empty      (qb_empty)
  );

  wfe_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .q_empty      (qb_empty),
    .q_entry      (qb_entry),
    .q_pop        (qb_pop),
    .empty        (empty),
    .pop          (pop),
    .duty         (duty),
    .last_of_item (last_of_item),
    .frame_end    (frame_end)
  );

endmodule

### hdl/wfe_front.sv
// ----------------------------------------------------------------------------
// wfe_front
// Accepts LED items, tracks the frame position and builds the dimmed GRB word.
// ----------------------------------------------------------------------------
module wfe_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         red,
  input  logic [7:0]         green,
  input  logic [7:0]         blue,
  input  logic [7:0]         brightness,
  output logic               q_push,
  output wfe_pkg::entry_t    q_entry,
  input  logic               q_full
);

  logic                             s_valid;
  logic [7:0]                       s_red;
  logic [7:0]                       s_green;
  logic [7:0]                       s_blue;
  logic [wfe_pkg::ANGLE_W-1:0]      s_angle;
  logic                             s_frame_last;
  logic [wfe_pkg::LED_W-1:0]        led_index;
  logic                             accept;
  logic                             is_last_led;
  logic [wfe_pkg::ANGLE_W-1:0]      angle_clamped;
  logic [wfe_pkg::COEF_W-1:0]       coef;
  logic [wfe_pkg::COEF_W+7:0]       prod_r;
  logic [wfe_pkg::COEF_W+7:0]       prod_g;
  logic [wfe_pkg::COEF_W+7:0]       prod_b;

  assign full   = s_valid && q_full;
  assign accept = push && !full;
  assign q_push = s_valid && !q_full;

  assign is_last_led   = led_index >= wfe_pkg::LED_W'(wfe_pkg::NUM_LEDS - 1);
  assign angle_clamped = (brightness > 8'(wfe_pkg::MAX_ANGLE)) ?
                         wfe_pkg::ANGLE_W'(wfe_pkg::MAX_ANGLE) :
                         brightness[wfe_pkg::ANGLE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid   <= 1'b0;
      led_index <= '0;
    end else begin
      s_valid <= accept || (s_valid && !q_push);
      if (accept) begin
        led_index <= is_last_led ? '0 : led_index + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_red        <= red;
      s_green      <= green;
      s_blue       <= blue;
      s_angle      <= angle_clamped;
      s_frame_last <= is_last_led;
    end
  end

  // q1.16 scale, truncated
  assign coef   = wfe_pkg::tan_coef(s_angle);
  assign prod_r = (wfe_pkg::COEF_W+8)'(s_red)   * (wfe_pkg::COEF_W+8)'(coef);
  assign prod_g = (wfe_pkg::COEF_W+8)'(s_green) * (wfe_pkg::COEF_W+8)'(coef);
  assign prod_b = (wfe_pkg::COEF_W+8)'(s_blue)  * (wfe_pkg::COEF_W+8)'(coef);

  assign q_entry.word       = {prod_g[23:16], prod_r[23:16], prod_b[23:16]};
  assign q_entry.frame_last = s_frame_last;

endmodule

### hdl/wfe_queue.sv
// ----------------------------------------------------------------------------
// wfe_queue
// Short register queue between the front and back halves.
// ----------------------------------------------------------------------------
module wfe_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  wfe_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output wfe_pkg::entry_t pop_entry,
  output logic            empty
);

  wfe_pkg::entry_t                slots [wfe_pkg::QUEUE_DEPTH];
  logic [wfe_pkg::QPTR_W-1:0]     wr_ptr;
  logic [wfe_pkg::QPTR_W-1:0]     rd_ptr;
  logic [wfe_pkg::QCNT_W-1:0]     count;
  logic                           do_push;
  logic                           do_pop;

  assign full      = count == wfe_pkg::QCNT_W'(wfe_pkg::QUEUE_DEPTH);
  assign empty     = count == '0;
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign pop_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == wfe_pkg::QPTR_W'(wfe_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == wfe_pkg::QPTR_W'(wfe_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_entry;
  end

endmodule

### hdl/wfe_back.sv
// ----------------------------------------------------------------------------
// wfe_back
// Serializes queued words into duty slots, appends the frame reset slots.
// ----------------------------------------------------------------------------
module wfe_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [7:0]       cfg_data,
  input  logic             q_empty,
  input  wfe_pkg::entry_t  q_entry,
  output logic             q_pop,
  output logic             empty,
  input  logic             pop,
  output logic [7:0]       duty,
  output logic             last_of_item,
  output logic             frame_end
);

  logic [7:0]                         timer_top;
  logic [31:0]                        one_prod;
  logic [31:0]                        zero_prod;
  logic [7:0]                         duty_one;
  logic [7:0]                         duty_zero;
  logic                               out_valid;
  logic                               cur_active;
  logic [wfe_pkg::BITS_PER_LED-1:0]   cur_word;
  logic                               cur_frame_last;
  logic [wfe_pkg::SLOT_W-1:0]         cnt;
  logic                               adv;
  logic                               last_slot;
  logic                               load;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timer_top <= 8'd89;
    end else if (cfg_valid) begin
      timer_top <= cfg_data;
    end
  end

  // floor(top*66/100) and floor(top*33/100) through a reciprocal multiply
  assign one_prod  = 32'(timer_top) * 32'(wfe_pkg::ONE_MULT);
  assign zero_prod = 32'(timer_top) * 32'(wfe_pkg::ZERO_MULT);

  always_ff @(posedge clk) begin
    duty_one  <= one_prod[wfe_pkg::DIV100_SHIFT +: 8];
    duty_zero <= zero_prod[wfe_pkg::DIV100_SHIFT +: 8];
  end

  assign empty     = !out_valid;
  assign adv       = !out_valid || pop;
  assign last_slot = cnt == (cur_frame_last ? wfe_pkg::SLOT_W'(wfe_pkg::MAX_SLOTS - 1) :
                                              wfe_pkg::SLOT_W'(wfe_pkg::BITS_PER_LED - 1));
  assign load      = !q_empty && (!cur_active || (adv && last_slot));
  assign q_pop     = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      cur_active <= 1'b0;
    end else begin
      if (adv) out_valid <= cur_active;
      if (load) begin
        cur_active <= 1'b1;
      end else if (adv && last_slot) begin
        cur_active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && cur_active) begin
      // msb first while in the bit slots, zero duty in the reset slots
      if (cnt < wfe_pkg::SLOT_W'(wfe_pkg::BITS_PER_LED)) begin
        duty <= cur_word[wfe_pkg::BITS_PER_LED-1] ? duty_one : duty_zero;
      end else begin
        duty <= 8'd0;
      end
      last_of_item <= last_slot;
      frame_end    <= last_slot && cur_frame_last;
    end
    if (load) begin
      cur_word       <= q_entry.word;
      cur_frame_last <= q_entry.frame_last;
      cnt            <= '0;
    end else if (adv && cur_active) begin
      cur_word <= cur_word << 1;
      cnt      <= cnt + 1'b1;
    end
  end

endmodule
